// ----- hdl/qse_pkg.sv -----
// shared types, constants and decode table for the quadrature speed estimator
`timescale 1ns / 1ps

package qse_pkg;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_RPM    = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  // register reset values
  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [23:0] RPM_RESET    = 24'd4096;
  localparam logic [15:0] ALPHA_RESET  = 16'd2048;

  // range limits
  localparam logic signed [17:0] NET_POS_LIM = 18'sd65535;
  localparam logic signed [17:0] NET_NEG_LIM = -18'sd65535;
  localparam logic signed [41:0] SPD_MAX     = 42'sd8388607;
  localparam logic signed [41:0] SPD_MIN     = -42'sd8388608;

  // x4 decode: index is {previous phase, current phase}, phase = {a, b}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0,  2'sd1, -2'sd1,  2'sd0, -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd1,  2'sd0,  2'sd0, -2'sd1,  2'sd0, -2'sd1,  2'sd1,  2'sd0
  };

  // configuration register set
  typedef struct packed {
    logic [15:0] window_samples;
    logic [23:0] rpm_per_count;
    logic [15:0] smoothing_alpha;
  } qse_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic sample_en;
    logic mul1_en;
    logic clip1_en;
    logic mul2_en;
    logic upd_en;
    logic out_load;
  } qse_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic win_end;
  } qse_status_t;

  // controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL1  = 6'b000010,
    ST_CLIP1 = 6'b000100,
    ST_MUL2  = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_OUT   = 6'b100000
  } qse_state_e;

endpackage

// ----- hdl/qse_regs.sv -----
// apb configuration registers of the quadrature speed estimator
`timescale 1ns / 1ps

module qse_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output qse_pkg::qse_cfg_t cfg_o
);
  import qse_pkg::*;

  logic [15:0] window_q;
  logic [23:0] rpm_q;
  logic [15:0] alpha_q;
  logic        wr_en;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes on the access phase of a write transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      rpm_q    <= RPM_RESET;
      alpha_q  <= ALPHA_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_WINDOW: window_q <= pwdata[15:0];
        REG_RPM:    rpm_q    <= pwdata[23:0];
        REG_ALPHA:  alpha_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_WINDOW: prdata = {16'd0, window_q};
      REG_RPM:    prdata = {8'd0, rpm_q};
      REG_ALPHA:  prdata = {16'd0, alpha_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o.window_samples  = window_q;
  assign cfg_o.rpm_per_count   = rpm_q;
  assign cfg_o.smoothing_alpha = alpha_q;

endmodule

// ----- hdl/qse_ctrl.sv -----
// controller state machine: sample intake, window-end math sequence, output slot
`timescale 1ns / 1ps

module qse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  qse_pkg::qse_status_t status_i,
  output qse_pkg::qse_cmd_t    cmd_o
);
  import qse_pkg::*;

  qse_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       take;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign take        = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (take && status_i.win_end) state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_CLIP1;
      ST_CLIP1: state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_UPD;
      ST_UPD:   state_d = ST_OUT;
      ST_OUT:   if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.sample_en = take;
    cmd_o.mul1_en   = (state_q == ST_MUL1);
    cmd_o.clip1_en  = (state_q == ST_CLIP1);
    cmd_o.mul2_en   = (state_q == ST_MUL2);
    cmd_o.upd_en    = (state_q == ST_UPD);
    cmd_o.out_load  = (state_q == ST_OUT) & slot_free;
  end

  // output valid: set on load, cleared when the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)             out_valid_d = 1'b1;
    else if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/qse_dp.sv -----
// datapath: quadrature decode, window counters, speed scaling and smoothing
`timescale 1ns / 1ps

module qse_dp #(
  parameter int WINDOW_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 phase_a_i,
  input  logic                 phase_b_i,
  input  qse_pkg::qse_cfg_t    cfg_i,
  input  qse_pkg::qse_cmd_t    cmd_i,
  output qse_pkg::qse_status_t status_o,
  output logic signed [23:0]   filtered_speed_o,
  output logic signed [16:0]   window_net_counts_o,
  output logic                 speed_saturated_o
);
  import qse_pkg::*;

  localparam int LW = (WINDOW_BITS > 16) ? WINDOW_BITS : 16;
  localparam logic [WINDOW_BITS-1:0] CNT_MAX = {WINDOW_BITS{1'b1}};

  // decode and window state
  logic [1:0]               prev_q;
  logic                     pvalid_q;
  logic signed [16:0]       net_q;
  logic [WINDOW_BITS-1:0]   seen_q;
  logic signed [23:0]       smooth_q;

  // window-end pipeline registers
  logic signed [16:0]       count_q;
  logic signed [41:0]       prod1_q;
  logic signed [23:0]       raw_q;
  logic                     sat_q;
  logic signed [41:0]       prod2_q;

  logic [1:0]               cur;
  logic signed [1:0]        step;
  logic signed [17:0]       net_sum;
  logic signed [16:0]       net_new;
  logic [WINDOW_BITS-1:0]   seen_inc;
  logic [LW-1:0]            ws_ext;
  logic [LW-1:0]            lim_ext;
  logic [WINDOW_BITS-1:0]   limit;
  logic signed [41:0]       rnd1;
  logic signed [24:0]       diff;
  logic signed [41:0]       rnd2;
  logic signed [41:0]       sm_sum;

  // quadrature step with saturating net count
  assign cur     = {phase_a_i, phase_b_i};
  assign step    = pvalid_q ? STEP_TABLE[{prev_q, cur}] : 2'sd0;
  assign net_sum = 18'(net_q) + 18'(step);
  always_comb begin
    if (net_sum > NET_POS_LIM)      net_new = 17'(NET_POS_LIM);
    else if (net_sum < NET_NEG_LIM) net_new = 17'(NET_NEG_LIM);
    else                            net_new = net_sum[16:0];
  end

  // effective window length: zero acts as one, clipped to counter range
  assign ws_ext = LW'(cfg_i.window_samples);
  always_comb begin
    if (ws_ext == '0)                 lim_ext = LW'(1);
    else if (ws_ext > LW'(CNT_MAX))   lim_ext = LW'(CNT_MAX);
    else                              lim_ext = ws_ext;
  end
  assign limit = lim_ext[WINDOW_BITS-1:0];

  assign seen_inc         = (seen_q == CNT_MAX) ? seen_q : seen_q + WINDOW_BITS'(1);
  assign status_o.win_end = (seen_inc >= limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 2'd0;
      pvalid_q <= 1'b0;
      net_q    <= '0;
      seen_q   <= '0;
    end else if (cmd_i.sample_en) begin
      prev_q   <= cur;
      pvalid_q <= 1'b1;
      if (status_o.win_end) begin
        net_q  <= '0;
        seen_q <= '0;
      end else begin
        net_q  <= net_new;
        seen_q <= seen_inc;
      end
    end
  end

  // capture the finished window count
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_en && status_o.win_end) count_q <= net_new;
  end

  // raw speed: count times scale, round by 4 bits ties away from zero
  assign rnd1 = (prod1_q + (prod1_q[41] ? 42'sd7 : 42'sd8)) >>> 4;

  // smoothing: alpha times difference, round by 16 bits ties away from zero
  assign diff   = 25'(raw_q) - 25'(smooth_q);
  assign rnd2   = (prod2_q + (prod2_q[41] ? 42'sd32767 : 42'sd32768)) >>> 16;
  assign sm_sum = rnd2 + 42'(smooth_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1_en) begin
      prod1_q <= 42'(count_q * $signed({1'b0, cfg_i.rpm_per_count}));
    end
    if (cmd_i.clip1_en) begin
      if (rnd1 > SPD_MAX) begin
        raw_q <= 24'(SPD_MAX);
        sat_q <= 1'b1;
      end else if (rnd1 < SPD_MIN) begin
        raw_q <= 24'(SPD_MIN);
        sat_q <= 1'b1;
      end else begin
        raw_q <= rnd1[23:0];
        sat_q <= 1'b0;
      end
    end
    if (cmd_i.mul2_en) begin
      prod2_q <= 42'(diff * $signed({1'b0, cfg_i.smoothing_alpha}));
    end
    if (cmd_i.upd_en && ((sm_sum > SPD_MAX) || (sm_sum < SPD_MIN))) begin
      sat_q <= 1'b1;
    end
  end

  // smoothed speed state, saturated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
    end else if (cmd_i.upd_en) begin
      if (sm_sum > SPD_MAX)      smooth_q <= 24'(SPD_MAX);
      else if (sm_sum < SPD_MIN) smooth_q <= 24'(SPD_MIN);
      else                       smooth_q <= sm_sum[23:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      filtered_speed_o    <= smooth_q;
      window_net_counts_o <= count_q;
      speed_saturated_o   <= sat_q;
    end
  end

endmodule

// ----- hdl/quadrature_speed_estimator.sv -----
// top level of the quadrature speed estimator
`timescale 1ns / 1ps

// X4 quadrature decoder with windowed speed output. Each transfer on the
// input channel carries one sample of encoder lines A and B. After the
// configured number of samples the net count is scaled by rpm_per_count
// (Q12.12), smoothed by a first-order exponential filter with weight
// smoothing_alpha (Q0.16) and delivered as one signed Q16.8 speed together
// with the window's net count and a saturation flag. The window-end math
// runs through a multiply sequence (scale multiply, round and clip, filter
// multiply, update, output load); during this sequence in_ready_o is low,
// and it stays low longer only if the previous result has not yet been
// taken. Between window ends the block takes one sample per cycle.
// Registers: window_samples at 0x0, rpm_per_count at 0x4, smoothing_alpha
// at 0x8.
module quadrature_speed_estimator #(
  parameter int WINDOW_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               phase_a_i,
  input  logic               phase_b_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic signed [23:0] filtered_speed_o,
  output logic signed [16:0] window_net_counts_o,
  output logic               speed_saturated_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import qse_pkg::*;

  qse_cfg_t    cfg;
  qse_cmd_t    cmd;
  qse_status_t status;

  // configuration registers
  qse_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencing
  qse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // decode and arithmetic
  qse_dp #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .phase_a_i           (phase_a_i),
    .phase_b_i           (phase_b_i),
    .cfg_i               (cfg),
    .cmd_i               (cmd),
    .status_o            (status),
    .filtered_speed_o    (filtered_speed_o),
    .window_net_counts_o (window_net_counts_o),
    .speed_saturated_o   (speed_saturated_o)
  );

endmodule

// ----- hdl/qse_checker.sv -----
// port-level checks for the quadrature speed estimator, bound to the top level
`timescale 1ns / 1ps

module qse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [23:0] filtered_speed_o,
  input logic signed [16:0] window_net_counts_o,
  input logic               speed_saturated_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(filtered_speed_o) && $stable(window_net_counts_o)
       && $stable(speed_saturated_o)))
    else $error("result changed while stalled");

  // net count of a window never goes past the saturation limit
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_net_counts_o != $signed(17'h1_0000)))
    else $error("window net count out of range");

  // a new result only appears after sample intake has paused
  a_rise_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without window-end sequence");

  // window-end math still holds off samples in the cycle after intake stops
  a_stall_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |=> !in_ready_o)
    else $error("window-end stall too short");

endmodule

bind quadrature_speed_estimator qse_checker u_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .filtered_speed_o    (filtered_speed_o),
  .window_net_counts_o (window_net_counts_o),
  .speed_saturated_o   (speed_saturated_o)
);

// ----- bench/quadrature_speed_estimator_tb.sv -----
// testbench for the quadrature speed estimator: x4 decode, windowed speed and smoothing checks
`timescale 1ns / 1ps

module quadrature_speed_estimator_tb;
  import qse_pkg::*;

  // register values after reset
  localparam logic [15:0] WINDOW_AT_RESET = 16'd1000;
  localparam logic [23:0] RPM_AT_RESET    = 24'd4096;
  localparam logic [15:0] ALPHA_AT_RESET  = 16'd2048;

  // speed range, signed q16.8
  localparam longint SPEED_TOP    = 64'sd8388607;
  localparam longint SPEED_BOTTOM = -64'sd8388608;
  localparam int     COUNT_LIMIT  = 65535;

  // receiver hold-off length for the backpressure phase
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic a;
    logic b;
  } line_sample_t;

  typedef struct packed {
    logic signed [23:0] speed;
    logic signed [16:0] net;
    logic               sat;
  } speed_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               phase_a_i   = 1'b0;
  logic               phase_b_i   = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] filtered_speed_o;
  logic signed [16:0] window_net_counts_o;
  logic               speed_saturated_o;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [3:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  // encoder samples waiting to be offered, and speeds waiting to be seen
  line_sample_t  pending_samples[$];
  speed_result_t expected_speeds[$];

  int unsigned samples_queued   = 0;
  int unsigned samples_taken    = 0;
  int unsigned speeds_predicted = 0;
  int unsigned speeds_checked   = 0;
  int unsigned mismatch_count   = 0;

  // idling control shared by both sides, and the receiver's hold-off trigger
  bit idle_en     = 1'b1;
  bit hold_off_go = 1'b0;

  // idle and hold-off counters of sender and receiver
  int unsigned src_gap  = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_cnt = 0;
  bit          hold_off_done = 1'b0;

  // predictor copy of the registers
  logic [15:0] cfg_window = WINDOW_AT_RESET;
  logic [23:0] cfg_rpm    = RPM_AT_RESET;
  logic [15:0] cfg_alpha  = ALPHA_AT_RESET;

  // predictor state
  logic [1:0]  last_lines        = 2'b00;
  bit          have_last         = 1'b0;
  int          window_count      = 0;
  int unsigned samples_in_window = 0;
  longint      smoothed_rpm      = 0;

  // position along the gray sequence for generated walks
  logic [1:0] walk_pos = 2'd0;

  quadrature_speed_estimator u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .phase_a_i           (phase_a_i),
    .phase_b_i           (phase_b_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .filtered_speed_o    (filtered_speed_o),
    .window_net_counts_o (window_net_counts_o),
    .speed_saturated_o   (speed_saturated_o),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #10 clk_i = ~clk_i;

  // one line per mismatch
  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // round to nearest, ties away from zero
  function automatic longint round_away(longint v, int unsigned sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clip_speed(longint v, ref bit clipped);
    if (v > SPEED_TOP) begin
      clipped = 1'b1;
      return SPEED_TOP;
    end
    if (v < SPEED_BOTTOM) begin
      clipped = 1'b1;
      return SPEED_BOTTOM;
    end
    return v;
  endfunction

  // decode one sample and, at window end, work out the speed transfer
  task automatic track_encoder_sample(logic a, logic b);
    logic [1:0]    pos_now;
    logic [1:0]    pos_old;
    logic [1:0]    delta;
    int unsigned   span;
    longint        raw;
    longint        sm;
    bit            clipped;
    speed_result_t res;
    // position on the gray cycle 00 -> 01 -> 11 -> 10
    pos_now = {a, a ^ b};
    if (have_last) begin
      pos_old = {last_lines[1], last_lines[1] ^ last_lines[0]};
      delta   = pos_now - pos_old;
      if (delta == 2'd1) window_count++;
      else if (delta == 2'd3) window_count--;
      if (window_count > COUNT_LIMIT) window_count = COUNT_LIMIT;
      if (window_count < -COUNT_LIMIT) window_count = -COUNT_LIMIT;
    end
    last_lines = {a, b};
    have_last  = 1'b1;
    // a zero window behaves as one sample
    span = (cfg_window == 16'd0) ? 1 : {16'd0, cfg_window};
    if (samples_in_window < COUNT_LIMIT) samples_in_window++;
    if (samples_in_window >= span) begin
      clipped = 1'b0;
      raw = round_away(longint'(window_count) * longint'(cfg_rpm), 4);
      raw = clip_speed(raw, clipped);
      sm  = smoothed_rpm + round_away((raw - smoothed_rpm) * longint'(cfg_alpha), 16);
      sm  = clip_speed(sm, clipped);
      smoothed_rpm = sm;
      res.speed = sm[23:0];
      res.net   = window_count[16:0];
      res.sat   = clipped;
      expected_speeds.push_back(res);
      speeds_predicted++;
      window_count      = 0;
      samples_in_window = 0;
    end
  endtask

  // sender: offers queued samples, holds each until the transfer
  always @(posedge clk_i) begin
    line_sample_t nxt;
    logic         give;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_encoder_sample(phase_a_i, phase_b_i);
        samples_taken++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        give = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 9);
        end else if (pending_samples.size() > 0) begin
          nxt  = pending_samples.pop_front();
          give = 1'b1;
          phase_a_i <= nxt.a;
          phase_b_i <= nxt.b;
        end
        in_valid_i <= give;
      end
    end
  end

  // receiver: checks each speed transfer and drives ready
  always @(posedge clk_i) begin
    speed_result_t want;
    logic          take;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_speeds.size() == 0) begin
          report_mismatch("speed transfer with none expected", filtered_speed_o, 0);
        end else begin
          want = expected_speeds.pop_front();
          if (filtered_speed_o !== want.speed)
            report_mismatch("filtered_speed", filtered_speed_o, want.speed);
          if (window_net_counts_o !== want.net)
            report_mismatch("window_net_counts", window_net_counts_o, want.net);
          if (speed_saturated_o !== want.sat)
            report_mismatch("speed_saturated", speed_saturated_o, want.sat);
          speeds_checked++;
        end
      end
      // long hold-off once, then random stall bursts
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_cnt      = HOLD_OFF_CYCLES;
      end
      take = 1'b0;
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (sink_gap > 0) begin
        sink_gap--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 9);
      end else begin
        take = 1'b1;
      end
      out_ready_i <= take;
    end
  end

  task automatic push_lines(logic a, logic b);
    line_sample_t s;
    s.a = a;
    s.b = b;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // mostly legal steps in one direction, with back steps, holds and illegal jumps
  task automatic queue_walk(int unsigned count, logic [1:0] dir);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 70) walk_pos += dir;
      else if (r < 82) walk_pos -= dir;
      else if (r >= 92) walk_pos += 2'd2;
      push_lines(walk_pos[1], walk_pos[1] ^ walk_pos[0]);
    end
  endtask

  task automatic check_reg(logic [1:0] idx, logic [31:0] want);
    logic [31:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch("register readback", got, want);
  endtask

  // apb write, then mirror into the predictor and read back
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    logic [31:0] masked;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    masked = '0;
    case (idx)
      REG_WINDOW: begin
        cfg_window    = data[15:0];
        masked[15:0]  = data[15:0];
      end
      REG_RPM: begin
        cfg_rpm       = data[23:0];
        masked[23:0]  = data[23:0];
      end
      REG_ALPHA: begin
        cfg_alpha     = data[15:0];
        masked[15:0]  = data[15:0];
      end
      default: ;
    endcase
    check_reg(idx, masked);
  endtask

  // wait until everything sent is taken and every speed is checked
  task automatic settle();
    wait (samples_taken == samples_queued);
    wait (speeds_checked == speeds_predicted);
    repeat (12) @(posedge clk_i);
  endtask

  // every ordered pair of line states, starting from 01 as the first sample
  localparam logic [1:0] TOUR [17] = '{
    2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1, 2'd2, 2'd1,
    2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0, 2'd1
  };

  initial begin
    logic [31:0] junk;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register values after reset
    check_reg(REG_WINDOW, {16'd0, WINDOW_AT_RESET});
    check_reg(REG_RPM, {8'd0, RPM_AT_RESET});
    check_reg(REG_ALPHA, {16'd0, ALPHA_AT_RESET});

    // first sample only records the phase, then all sixteen transitions
    foreach (TOUR[i]) push_lines(TOUR[i][1], TOUR[i][0]);
    walk_pos = 2'd1;
    settle();

    // zero window with upper bits set: window ends on the next sample
    write_reg(REG_WINDOW, 32'hABCD_0000);
    queue_walk(4, 2'd1);
    settle();

    // random phases over window size, scale and smoothing weight
    for (int ph = 0; ph < 16; ph++) begin
      int unsigned k;
      int unsigned w;
      int unsigned n;
      logic [1:0]  dir;
      logic [23:0] rpm;
      logic [15:0] alpha;
      k = $urandom_range(0, 9);
      if (k == 0) w = 0;
      else if (k == 1) w = 1;
      else if (k < 4) w = $urandom_range(2, 8);
      else w = $urandom_range(9, 96);
      case ($urandom_range(0, 3))
        0: rpm = 24'd0;
        1: rpm = 24'hFFFFFF;
        2: rpm = 24'($urandom);
        default: rpm = 24'($urandom_range(1, 16383));
      endcase
      case ($urandom_range(0, 2))
        0: alpha = 16'd0;
        1: alpha = 16'hFFFF;
        default: alpha = 16'($urandom);
      endcase
      dir = $urandom_range(0, 1) ? 2'd1 : 2'd3;
      // first two phases drive the speed into both clip limits
      if (ph < 2) begin
        w     = 32;
        rpm   = 24'hFFFFFF;
        alpha = 16'hFFFF;
        dir   = (ph == 0) ? 2'd1 : 2'd3;
      end
      if (ph == 8) w = 1;
      n = (w < 2) ? $urandom_range(10, 40) : w * $urandom_range(1, 2) + $urandom_range(0, w);
      junk = $urandom;
      write_reg(REG_WINDOW, {junk[31:16], w[15:0]});
      write_reg(REG_RPM, {junk[31:24], rpm});
      write_reg(REG_ALPHA, {junk[15:0], alpha});
      // backpressure: receiver holds off while one-sample windows keep coming
      if (ph == 8) begin
        hold_off_go = 1'b1;
        n = 60;
      end
      queue_walk(n, dir);
      settle();
    end

    // close any open window so the last one starts empty
    junk = $urandom;
    write_reg(REG_WINDOW, {junk[31:16], 16'd0});
    queue_walk(1, 2'd1);
    settle();

    // long window, steady rotation, largest scale, no idling
    idle_en = 1'b0;
    junk = $urandom;
    write_reg(REG_WINDOW, {junk[31:16], 16'd300});
    write_reg(REG_RPM, {junk[31:24], 24'hFFFFFF});
    write_reg(REG_ALPHA, {junk[31:16], junk[15:0]});
    repeat (300) begin
      walk_pos += 2'd1;
      push_lines(walk_pos[1], walk_pos[1] ^ walk_pos[0]);
    end
    queue_walk(20, 2'd3);
    settle();
    repeat (20) @(posedge clk_i);

    if (expected_speeds.size() != 0)
      report_mismatch("speeds never delivered", 0, expected_speeds.size());
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
